// File: sv/dsd_pkg.sv
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared widths, command codes and pipeline word types for the divider.
// ----------------------------------------------------------------------------
package dsd_pkg;

    localparam int DATA_W          = 32;
    localparam int STEPS_PER_STAGE = 2;   // conditional subtracts per stage

    localparam logic [1:0] CMD_UDIV = 2'd0;
    localparam logic [1:0] CMD_UREM = 2'd1;
    localparam logic [1:0] CMD_SDIV = 2'd2;
    localparam logic [1:0] CMD_SREM = 2'd3;

    typedef struct packed {
        logic neg_q;     // quotient gets negated
        logic neg_r;     // remainder gets negated (dividend was negative)
        logic sel_rem;   // deliver remainder instead of quotient
        logic den_zero;  // divisor was zero
    } dsd_ctrl_t;

    typedef struct packed {
        logic [DATA_W-1:0] rem;   // partial remainder
        logic [DATA_W-1:0] quo;   // dividend bits shifting out, quotient bits in
        logic [DATA_W-1:0] den;   // divisor magnitude
        dsd_ctrl_t         ctrl;
    } dsd_work_t;

endpackage

// File: sv/dsd_prep.sv
// ----------------------------------------------------------------------------
// dsd_prep
// Input stage: decodes the command and takes operand magnitudes.
// ----------------------------------------------------------------------------
module dsd_prep (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        valid_i,
    output logic                        ready_o,
    input  logic [1:0]                  cmd_i,
    input  logic [dsd_pkg::DATA_W-1:0]  dividend_i,
    input  logic [dsd_pkg::DATA_W-1:0]  divisor_i,
    output logic                        valid_o,
    input  logic                        ready_i,
    output dsd_pkg::dsd_work_t          work_o
);
    import dsd_pkg::*;

    logic       valid_reg;
    dsd_work_t  work_reg;
    dsd_work_t  work_next;
    logic       is_signed;
    logic       num_neg;
    logic       den_neg;

    assign ready_o = !valid_reg || ready_i;
    assign valid_o = valid_reg;
    assign work_o  = work_reg;

    always_comb begin
        is_signed = (cmd_i == CMD_SDIV) || (cmd_i == CMD_SREM);
        num_neg   = is_signed && dividend_i[DATA_W-1];
        den_neg   = is_signed && divisor_i[DATA_W-1];
        work_next.rem           = '0;
        work_next.quo           = num_neg ? (-dividend_i) : dividend_i;
        work_next.den           = den_neg ? (-divisor_i) : divisor_i;
        work_next.ctrl.neg_q    = num_neg ^ den_neg;
        work_next.ctrl.neg_r    = num_neg;
        work_next.ctrl.sel_rem  = (cmd_i == CMD_UREM) || (cmd_i == CMD_SREM);
        work_next.ctrl.den_zero = (divisor_i == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            work_reg <= work_next;
        end
    end

endmodule

// File: sv/dsd_step_stage.sv
// ----------------------------------------------------------------------------
// dsd_step_stage
// One pipeline stage of restoring division: STEPS shift/subtract steps.
// ----------------------------------------------------------------------------
module dsd_step_stage #(
    parameter int STEPS = dsd_pkg::STEPS_PER_STAGE
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                valid_i,
    output logic                ready_o,
    input  dsd_pkg::dsd_work_t  work_i,
    output logic                valid_o,
    input  logic                ready_i,
    output dsd_pkg::dsd_work_t  work_o
);
    import dsd_pkg::*;

    logic       valid_reg;
    dsd_work_t  work_reg;
    dsd_work_t  work_next;

    assign ready_o = !valid_reg || ready_i;
    assign valid_o = valid_reg;
    assign work_o  = work_reg;

    always_comb begin
        logic [DATA_W:0] shifted;
        logic [DATA_W:0] diff;
        work_next = work_i;
        for (int k = 0; k < STEPS; k++) begin
            shifted = {work_next.rem, work_next.quo[DATA_W-1]};
            diff    = shifted - {1'b0, work_next.den};
            // borrow out means the trial subtract failed: restore
            work_next.quo = {work_next.quo[DATA_W-2:0], ~diff[DATA_W]};
            work_next.rem = diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            work_reg <= work_next;
        end
    end

endmodule

// File: sv/dsd_post.sv
// ----------------------------------------------------------------------------
// dsd_post
// Output stage: sign correction, zero-divisor handling and result select.
// ----------------------------------------------------------------------------
module dsd_post (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        valid_i,
    output logic                        ready_o,
    input  dsd_pkg::dsd_work_t          work_i,
    output logic                        valid_o,
    input  logic                        ready_i,
    output logic [dsd_pkg::DATA_W-1:0]  result_o
);
    import dsd_pkg::*;

    logic              valid_reg;
    logic [DATA_W-1:0] result_reg;
    logic [DATA_W-1:0] result_next;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] quo_fix;
    logic [DATA_W-1:0] rem_fix;

    assign ready_o  = !valid_reg || ready_i;
    assign valid_o  = valid_reg;
    assign result_o = result_reg;

    always_comb begin
        // zero divisor leaves all ones in the quotient; force it to zero
        quo         = work_i.ctrl.den_zero ? '0 : work_i.quo;
        quo_fix     = work_i.ctrl.neg_q ? (-quo) : quo;
        rem_fix     = work_i.ctrl.neg_r ? (-work_i.rem) : work_i.rem;
        result_next = work_i.ctrl.sel_rem ? rem_fix : quo_fix;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            result_reg <= result_next;
        end
    end

endmodule

// File: sv/divide_32bit_signed_unsigned_core.sv
// ----------------------------------------------------------------------------
// divide_32bit_signed_unsigned_core
// Pipelined 32-bit signed/unsigned divider returning quotient or remainder.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready carries one word: s_cmd, s_dividend and
//   s_divisor. s_cmd selects unsigned quotient, unsigned remainder, signed
//   quotient or signed remainder. Output channel m_valid/m_ready carries
//   m_result. Signed commands truncate toward zero; the remainder takes the
//   sign of the dividend. A zero divisor gives quotient 0 and remainder equal
//   to the dividend; the most negative value over -1 wraps.
//   The pipeline is one input stage, the division stages and one output
//   register. Throughput is one word per cycle while m_ready is high; each
//   division stage holds STEPS_PER_STAGE dependent 33-bit conditional
//   subtracts, which set the clock period.
//   Reset clears all stage valid bits; the pipeline is empty afterwards.
//   When m_ready is low, stages fill up behind the output register and
//   s_ready drops once every stage holds a word; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module divide_32bit_signed_unsigned_core #(
    parameter int STEPS_PER_STAGE = dsd_pkg::STEPS_PER_STAGE
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_cmd,
    input  logic [dsd_pkg::DATA_W-1:0]  s_dividend,
    input  logic [dsd_pkg::DATA_W-1:0]  s_divisor,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [dsd_pkg::DATA_W-1:0]  m_result
);
    import dsd_pkg::*;

    localparam int NUM_STAGES = DATA_W / STEPS_PER_STAGE;

    logic      valid_w [NUM_STAGES+1];
    logic      ready_w [NUM_STAGES+1];
    dsd_work_t work_w  [NUM_STAGES+1];

    dsd_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .valid_i    (s_valid),
        .ready_o    (s_ready),
        .cmd_i      (s_cmd),
        .dividend_i (s_dividend),
        .divisor_i  (s_divisor),
        .valid_o    (valid_w[0]),
        .ready_i    (ready_w[0]),
        .work_o     (work_w[0])
    );

    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
        dsd_step_stage #(
            .STEPS (STEPS_PER_STAGE)
        ) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .valid_i (valid_w[i]),
            .ready_o (ready_w[i]),
            .work_i  (work_w[i]),
            .valid_o (valid_w[i+1]),
            .ready_i (ready_w[i+1]),
            .work_o  (work_w[i+1])
        );
    end

    dsd_post u_post (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .valid_i  (valid_w[NUM_STAGES]),
        .ready_o  (ready_w[NUM_STAGES]),
        .work_i   (work_w[NUM_STAGES]),
        .valid_o  (m_valid),
        .ready_i  (m_ready),
        .result_o (m_result)
    );

    // an accepted word lands in the input stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_w[0])
        else $error("accepted word missing from input stage");

    // a stalled input stage keeps its word
    a_prep_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_w[0] && !ready_w[0] |=> valid_w[0] && $stable(work_w[0]))
        else $error("input stage word changed under stall");

    // after all steps the remainder is below a nonzero divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_w[NUM_STAGES] && !work_w[NUM_STAGES].ctrl.den_zero
        |-> work_w[NUM_STAGES].rem < work_w[NUM_STAGES].den)
        else $error("final remainder not below divisor");

endmodule
